### rtl/core/mad_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mad_pkg
// Shared types, constants and the Bresenham step function of the decimator.
// ----------------------------------------------------------------------------
package mad_pkg;

	localparam int LEN_W      = 13;
	localparam int SAMPLE_W   = 16;
	localparam int MAG_W      = SAMPLE_W + 1;
	localparam int RUN_SHIFT  = 6;
	localparam int RUN_W      = RUN_SHIFT;
	localparam int CFG_IDX_W  = 2;
	localparam int STEP_CNT_W = 4;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W     = $clog2(QUEUE_DEPTH);

	localparam logic [LEN_W-1:0] MAX_LEN       = LEN_W'(4096);
	localparam logic [LEN_W-1:0] IN_LEN_RESET  = LEN_W'(1024);
	localparam logic [LEN_W-1:0] OUT_LEN_RESET = LEN_W'(256);
	localparam logic [RUN_W-1:0] RUN_LAST_CNT  = {RUN_W{1'b1}};

	localparam logic [CFG_IDX_W-1:0] CFG_IN_LEN  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_OUT_LEN = CFG_IDX_W'(1);

	typedef enum logic [1:0] {
		MODE_DECIM,
		MODE_PASS,
		MODE_REPEAT
	} mode_t;

	typedef struct packed {
		logic                busy;
		logic                restart;
		mode_t               mode;
		logic [LEN_W-1:0]    n_len;
		logic [LEN_W-1:0]    w_len;
		logic [LEN_W-1:0]    quot;
		logic [LEN_W-1:0]    left;
	} setup_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] sample;
		logic [MAG_W-1:0]    mag;
	} entry_t;

	typedef struct packed {
		logic [LEN_W-1:0] nb;
		logic [LEN_W-1:0] rem;
	} adv_t;

	// One Bresenham step: boundary moves by the quotient, plus one on carry.
	function automatic adv_t mad_advance(
		input logic [LEN_W-1:0] nb,
		input logic [LEN_W-1:0] rem,
		input logic [LEN_W-1:0] quot,
		input logic [LEN_W-1:0] left,
		input logic [LEN_W-1:0] w_len
	);
		logic [LEN_W:0] sum;
		logic           carry;
		adv_t           res;
		sum     = {1'b0, rem} + {1'b0, left};
		carry   = (sum >= {1'b0, w_len});
		res.nb  = LEN_W'(nb + quot + {{(LEN_W-1){1'b0}}, carry});
		res.rem = carry ? LEN_W'(sum - {1'b0, w_len}) : sum[LEN_W-1:0];
		return res;
	endfunction

endpackage

### rtl/core/mad_setup.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mad_setup
// Length registers, clamping, and a bit-serial divider for the step quotient.
// ----------------------------------------------------------------------------
module mad_setup
	import mad_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [LEN_W-1:0]     cfg_data,
	output setup_t               setup
);

	logic [LEN_W-1:0]      in_len_q;
	logic [LEN_W-1:0]      out_len_q;
	logic                  start_q;
	logic                  busy_q;
	logic                  done_q;
	logic [STEP_CNT_W-1:0] cnt_q;
	logic [LEN_W-1:0]      div_q;
	logic [LEN_W-1:0]      part_q;
	logic [LEN_W-1:0]      n_q;
	logic [LEN_W-1:0]      w_q;
	mode_t                 mode_q;

	logic [LEN_W-1:0]           n_eff;
	logic [LEN_W-1:0]           o_clip;
	logic [LEN_W-1:0]           w_eff;
	logic [LEN_W+RUN_SHIFT-1:0] cap;
	logic [LEN_W:0]             shifted;
	logic                       ge;
	mode_t                      mode_eff;

	always_comb begin
		if (in_len_q == '0) begin
			n_eff = LEN_W'(1);
		end else if (in_len_q > MAX_LEN) begin
			n_eff = MAX_LEN;
		end else begin
			n_eff = in_len_q;
		end
		if (out_len_q == '0) begin
			o_clip = LEN_W'(1);
		end else if (out_len_q > MAX_LEN) begin
			o_clip = MAX_LEN;
		end else begin
			o_clip = out_len_q;
		end
		cap = {n_eff, {RUN_SHIFT{1'b0}}};
		if ({{RUN_SHIFT{1'b0}}, o_clip} > cap) begin
			w_eff = cap[LEN_W-1:0];
		end else begin
			w_eff = o_clip;
		end
		if (n_eff > w_eff) begin
			mode_eff = MODE_DECIM;
		end else if (n_eff == w_eff) begin
			mode_eff = MODE_PASS;
		end else begin
			mode_eff = MODE_REPEAT;
		end
		shifted = {part_q, div_q[LEN_W-1]};
		ge      = (shifted >= {1'b0, w_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_len_q  <= IN_LEN_RESET;
			out_len_q <= OUT_LEN_RESET;
			start_q   <= 1'b1;
			busy_q    <= 1'b0;
			done_q    <= 1'b0;
			cnt_q     <= '0;
		end else begin
			done_q <= 1'b0;
			if (cfg_we && cfg_index == CFG_IN_LEN) begin
				in_len_q <= cfg_data;
				start_q  <= 1'b1;
			end else if (cfg_we && cfg_index == CFG_OUT_LEN) begin
				out_len_q <= cfg_data;
				start_q   <= 1'b1;
			end else if (start_q) begin
				start_q <= 1'b0;
				busy_q  <= 1'b1;
				cnt_q   <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + STEP_CNT_W'(1);
				if (cnt_q == STEP_CNT_W'(LEN_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start_q) begin
			div_q  <= n_eff;
			part_q <= '0;
			n_q    <= n_eff;
			w_q    <= w_eff;
			mode_q <= mode_eff;
		end else if (busy_q) begin
			div_q  <= {div_q[LEN_W-2:0], ge};
			part_q <= ge ? LEN_W'(shifted - {1'b0, w_q}) : shifted[LEN_W-1:0];
		end
	end

	assign setup.busy    = start_q | busy_q | done_q;
	assign setup.restart = done_q;
	assign setup.mode    = mode_q;
	assign setup.n_len   = n_q;
	assign setup.w_len   = w_q;
	assign setup.quot    = div_q;
	assign setup.left    = part_q;

endmodule

### rtl/core/mad_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mad_front
// Accepts sample words and tags each with its magnitude for the queue.
// ----------------------------------------------------------------------------
module mad_front
	import mad_pkg::*;
(
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  logic [SAMPLE_W-1:0] s_axis_tdata,
	input  logic                busy,
	input  logic                full,
	output logic                push,
	output entry_t              push_data
);

	logic [MAG_W-1:0] ext;

	assign s_axis_tready = !busy && !full;
	assign push          = s_axis_tvalid && s_axis_tready;
	assign ext           = {s_axis_tdata[SAMPLE_W-1], s_axis_tdata};

	always_comb begin
		push_data.sample = s_axis_tdata;
		push_data.mag    = s_axis_tdata[SAMPLE_W-1] ? (~ext + MAG_W'(1)) : ext;
	end

endmodule

### rtl/core/mad_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mad_queue
// Small first-in first-out queue between the front and back parts.
// ----------------------------------------------------------------------------
module mad_queue
	import mad_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_data,
	input  logic   pop,
	output logic   full,
	output logic   head_valid,
	output entry_t head
);

	entry_t          mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QPTR_W:0]   cnt_q;

	assign full       = (cnt_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head       = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + (QPTR_W+1)'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - (QPTR_W+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

endmodule

### rtl/core/mad_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mad_back
// Window peak tracking, pass-through and run repetition with Bresenham steps.
// ----------------------------------------------------------------------------
module mad_back
	import mad_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  setup_t              setup,
	input  logic                head_valid,
	input  entry_t              head,
	output logic                pop,
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	output logic [SAMPLE_W-1:0] m_axis_tdata,
	output logic                m_axis_tlast,
	output logic                m_axis_tuser
);

	logic [LEN_W-1:0]    in_idx_q, in_idx_d;
	logic [LEN_W-1:0]    out_idx_q, out_idx_d;
	logic [LEN_W-1:0]    nb_q, nb_d;
	logic [LEN_W-1:0]    rem_q, rem_d;
	logic [RUN_W-1:0]    run_q, run_d;
	logic                empty_q, empty_d;
	logic [SAMPLE_W-1:0] best_q, best_d;
	logic [MAG_W-1:0]    best_mag_q, best_mag_d;
	logic                vld_q;
	logic [SAMPLE_W-1:0] value_q;
	logic                rl_q;
	logic                fl_q;

	adv_t                adv;
	logic [LEN_W:0]      in_next;
	logic [LEN_W:0]      out_next;
	logic                fl_in;
	logic                fl_out;
	logic                fire;
	logic                take;
	logic                cond;
	logic                rl;
	logic                restart;
	logic                emit;
	logic [SAMPLE_W-1:0] emit_value;
	logic                emit_rl;
	logic                emit_fl;
	logic [SAMPLE_W-1:0] peak;
	logic [MAG_W-1:0]    peak_mag;

	always_comb begin
		adv      = mad_advance(nb_q, rem_q, setup.quot, setup.left, setup.w_len);
		in_next  = {1'b0, in_idx_q} + (LEN_W+1)'(1);
		out_next = {1'b0, out_idx_q} + (LEN_W+1)'(1);
		fl_in    = (in_next >= {1'b0, setup.n_len});
		fl_out   = (out_next >= {1'b0, setup.w_len});
		fire     = head_valid && (!vld_q || m_axis_tready) && !setup.busy;
		take     = empty_q || (head.mag > best_mag_q);
		peak     = take ? head.sample : best_q;
		peak_mag = take ? head.mag : best_mag_q;
		cond     = (nb_q == in_idx_q) && (out_idx_q < setup.w_len);
		rl       = fl_out || (adv.nb != in_idx_q) || (run_q == RUN_LAST_CNT);

		in_idx_d   = in_idx_q;
		out_idx_d  = out_idx_q;
		nb_d       = nb_q;
		rem_d      = rem_q;
		run_d      = run_q;
		empty_d    = empty_q;
		best_d     = best_q;
		best_mag_d = best_mag_q;
		pop        = 1'b0;
		emit       = 1'b0;
		emit_value = head.sample;
		emit_rl    = 1'b1;
		emit_fl    = 1'b0;
		restart    = setup.restart;

		case (setup.mode)
			MODE_DECIM: begin
				if (fire) begin
					pop = 1'b1;
					if (in_next >= {1'b0, nb_q}) begin
						emit       = 1'b1;
						emit_value = peak;
						emit_fl    = fl_out;
						if (fl_out) begin
							restart = 1'b1;
						end else begin
							in_idx_d  = in_next[LEN_W-1:0];
							out_idx_d = out_next[LEN_W-1:0];
							nb_d      = adv.nb;
							rem_d     = adv.rem;
							empty_d   = 1'b1;
						end
					end else begin
						in_idx_d   = in_next[LEN_W-1:0];
						empty_d    = 1'b0;
						best_d     = peak;
						best_mag_d = peak_mag;
					end
				end
			end
			MODE_PASS: begin
				if (fire) begin
					pop     = 1'b1;
					emit    = 1'b1;
					emit_fl = fl_in;
					if (fl_in) begin
						restart = 1'b1;
					end else begin
						in_idx_d  = in_next[LEN_W-1:0];
						out_idx_d = out_next[LEN_W-1:0];
					end
				end
			end
			MODE_REPEAT: begin
				if (fire) begin
					if (cond) begin
						emit    = 1'b1;
						emit_rl = rl;
						emit_fl = fl_out;
						if (rl) begin
							pop   = 1'b1;
							run_d = '0;
							if (fl_out || fl_in) begin
								restart = 1'b1;
							end else begin
								in_idx_d  = in_next[LEN_W-1:0];
								out_idx_d = out_next[LEN_W-1:0];
								nb_d      = adv.nb;
								rem_d     = adv.rem;
							end
						end else begin
							out_idx_d = out_next[LEN_W-1:0];
							nb_d      = adv.nb;
							rem_d     = adv.rem;
							run_d     = run_q + RUN_W'(1);
						end
					end else begin
						pop   = 1'b1;
						run_d = '0;
						if (fl_in) begin
							restart = 1'b1;
						end else begin
							in_idx_d = in_next[LEN_W-1:0];
						end
					end
				end
			end
			default: begin
			end
		endcase

		if (restart) begin
			in_idx_d   = '0;
			out_idx_d  = '0;
			run_d      = '0;
			empty_d    = 1'b1;
			best_d     = '0;
			best_mag_d = '0;
			nb_d       = (setup.mode == MODE_DECIM) ? setup.quot : '0;
			rem_d      = (setup.mode == MODE_DECIM) ? setup.left : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_idx_q  <= '0;
			out_idx_q <= '0;
			nb_q      <= '0;
			rem_q     <= '0;
			run_q     <= '0;
			empty_q   <= 1'b1;
			vld_q     <= 1'b0;
		end else begin
			in_idx_q  <= in_idx_d;
			out_idx_q <= out_idx_d;
			nb_q      <= nb_d;
			rem_q     <= rem_d;
			run_q     <= run_d;
			empty_q   <= empty_d;
			if (emit) begin
				vld_q <= 1'b1;
			end else if (m_axis_tready) begin
				vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		best_q     <= best_d;
		best_mag_q <= best_mag_d;
		if (emit) begin
			value_q <= emit_value;
			rl_q    <= emit_rl;
			fl_q    <= emit_fl;
		end
	end

	assign m_axis_tvalid = vld_q;
	assign m_axis_tdata  = value_q;
	assign m_axis_tlast  = rl_q;
	assign m_axis_tuser  = fl_q;

endmodule

### rtl/core/max_abs_decimator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_abs_decimator_unit
// Frame resampler: window peak by magnitude, pass-through, or sample repeat.
// ----------------------------------------------------------------------------
// When in_len exceeds out_len and when the lengths are equal, one sample word
// is taken every cycle while the output is ready, and at most one result word
// follows it. When in_len is smaller, results leave at one per cycle while the
// output is ready, and a sample holds the back end until it has sent all the
// results it causes, while a four-word queue keeps taking samples. After reset
// and after every register write the step quotient is found by a 13-step
// bit-serial divider; until it is done no sample word is accepted.
module max_abs_decimator_unit
	import mad_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [LEN_W-1:0]     cfg_data,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [SAMPLE_W-1:0]  s_axis_tdata,   // [15:0] sample
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [SAMPLE_W-1:0]  m_axis_tdata,   // [15:0] value
	output logic                 m_axis_tlast,
	output logic                 m_axis_tuser    // [0] frame_last
);

	setup_t setup;
	logic   full;
	logic   push;
	entry_t push_data;
	logic   pop;
	logic   head_valid;
	entry_t head;

	mad_setup u_setup (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.setup     (setup)
	);

	mad_front u_front (
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.busy          (setup.busy),
		.full          (full),
		.push          (push),
		.push_data     (push_data)
	);

	mad_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.pop        (pop),
		.full       (full),
		.head_valid (head_valid),
		.head       (head)
	);

	mad_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.setup         (setup),
		.head_valid    (head_valid),
		.head          (head),
		.pop           (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule
